>>> rtl/core/fsvp_pkg.sv
package fsvp_pkg;

    localparam int SLOT_MAX = 256;
    localparam int POS_W = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
    localparam int SLEN_W = $clog2(SLOT_MAX + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SLOT_CFG_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_STRING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_SLOT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CAPACITY = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OFFSET = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Everything the result side needs to replay the requests caused by one unit.
    typedef struct packed {
        logic            start;
        logic [2:0]      ndata;
        logic [3:0][7:0] bytes;
        logic            err;
        logic            slot_end;
        logic [31:0]     offset;
    } t_desc;

endpackage

>>> rtl/core/fsvp_front.sv
module fsvp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsvp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fsvp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_push,
    input  logic [31:0]                        i_unit,
    input  logic                               i_block_start,
    input  logic                               i_q_full,
    output logic                               o_full,
    output logic                               o_q_wr,
    output fsvp_pkg::t_desc                    o_q_desc
);

    logic                               r_string_mode;
    logic [fsvp_pkg::SLOT_CFG_W-1:0]    r_units_per_slot;
    logic [31:0]                        r_byte_capacity;
    logic [31:0]                        r_bytes_used;
    logic [fsvp_pkg::POS_W-1:0]         r_pos;
    logic                               r_term;
    logic                               r_ovf;

    logic [31:0]                        n_bytes_used;
    logic [fsvp_pkg::POS_W-1:0]         n_pos;
    logic                               n_term;
    logic                               n_ovf;

    logic                               accept;
    logic [fsvp_pkg::SLEN_W-1:0]        slot_len;
    logic [31:0]                        cp;
    logic [2:0]                         enc_n;
    logic [3:0][7:0]                    enc_b;
    logic [31:0]                        bu;
    logic [fsvp_pkg::POS_W-1:0]         pos;
    logic                               term;
    logic                               ovf;
    logic                               is_zero;
    logic [32:0]                        sum;
    logic [31:0]                        pos_inc;
    fsvp_pkg::t_desc                    desc;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;

    always_comb begin
        if (i_cfg_data[fsvp_pkg::SLOT_CFG_W-1:0] == '0 && r_units_per_slot == '0) begin
            slot_len = fsvp_pkg::SLEN_W'(1);
        end else if (r_units_per_slot == '0) begin
            slot_len = fsvp_pkg::SLEN_W'(1);
        end else if (32'(r_units_per_slot) > 32'(fsvp_pkg::SLOT_MAX)) begin
            slot_len = fsvp_pkg::SLEN_W'(fsvp_pkg::SLOT_MAX);
        end else begin
            slot_len = fsvp_pkg::SLEN_W'(r_units_per_slot);
        end
    end

    always_comb begin
        if (i_unit >= 32'h0011_0000 || (i_unit >= 32'h0000_D800 && i_unit <= 32'h0000_DFFF)) begin
            cp = 32'h0000_FFFD;
        end else begin
            cp = i_unit;
        end
        enc_b = '0;
        if (!r_string_mode) begin
            enc_n = 3'd1;
            enc_b[0] = i_unit[7:0];
        end else if (cp < 32'h80) begin
            enc_n = 3'd1;
            enc_b[0] = cp[7:0];
        end else if (cp < 32'h800) begin
            enc_n = 3'd2;
            enc_b[0] = 8'hC0 | {3'b0, cp[10:6]};
            enc_b[1] = 8'h80 | {2'b0, cp[5:0]};
        end else if (cp < 32'h1_0000) begin
            enc_n = 3'd3;
            enc_b[0] = 8'hE0 | {4'b0, cp[15:12]};
            enc_b[1] = 8'h80 | {2'b0, cp[11:6]};
            enc_b[2] = 8'h80 | {2'b0, cp[5:0]};
        end else begin
            enc_n = 3'd4;
            enc_b[0] = 8'hF0 | {5'b0, cp[20:18]};
            enc_b[1] = 8'h80 | {2'b0, cp[17:12]};
            enc_b[2] = 8'h80 | {2'b0, cp[11:6]};
            enc_b[3] = 8'h80 | {2'b0, cp[5:0]};
        end
    end

    always_comb begin
        bu   = i_block_start ? '0 : r_bytes_used;
        pos  = i_block_start ? '0 : r_pos;
        term = i_block_start ? 1'b0 : r_term;
        ovf  = i_block_start ? 1'b0 : r_ovf;

        desc          = '0;
        desc.start    = i_block_start;
        desc.bytes    = enc_b;
        is_zero       = r_string_mode ? (i_unit == '0) : (i_unit[7:0] == '0);
        sum           = {1'b0, bu} + 33'(enc_n);
        pos_inc       = 32'(pos) + 32'd1;

        n_bytes_used = bu;
        n_pos        = pos;
        n_term       = term;
        n_ovf        = ovf;

        if (!ovf) begin
            n_term = term || is_zero;
            if (!n_term) begin
                if (sum > {1'b0, r_byte_capacity}) begin
                    n_ovf    = 1'b1;
                    desc.err = 1'b1;
                end else begin
                    desc.ndata   = enc_n;
                    n_bytes_used = sum[31:0];
                end
            end
            if (!n_ovf) begin
                if (pos_inc >= 32'(slot_len)) begin
                    desc.slot_end = 1'b1;
                    desc.offset   = n_bytes_used;
                    n_pos         = '0;
                    n_term        = 1'b0;
                end else begin
                    n_pos = fsvp_pkg::POS_W'(pos_inc);
                end
            end
        end

        o_q_desc = desc;
        o_q_wr   = accept && (desc.start || desc.err || desc.slot_end || desc.ndata != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_mode    <= 1'b1;
            r_units_per_slot <= fsvp_pkg::SLOT_CFG_W'(8);
            r_byte_capacity  <= 32'hFFFF_FFFF;
            r_bytes_used     <= '0;
            r_pos            <= '0;
            r_term           <= 1'b0;
            r_ovf            <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fsvp_pkg::CFG_STRING_MODE: begin
                        r_string_mode <= i_cfg_data[0];
                    end
                    fsvp_pkg::CFG_UNITS_PER_SLOT: begin
                        r_units_per_slot <= i_cfg_data[fsvp_pkg::SLOT_CFG_W-1:0];
                    end
                    fsvp_pkg::CFG_BYTE_CAPACITY: begin
                        r_byte_capacity <= i_cfg_data[31:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_bytes_used <= n_bytes_used;
                r_pos        <= n_pos;
                r_term       <= n_term;
                r_ovf        <= n_ovf;
            end
        end
    end

endmodule

>>> rtl/core/fsvp_queue.sv
module fsvp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  fsvp_pkg::t_desc i_desc,
    input  logic            i_rd,
    output logic            o_full,
    output logic            o_valid,
    output fsvp_pkg::t_desc o_desc
);

    fsvp_pkg::t_desc                 r_mem [fsvp_pkg::QDEPTH];
    logic [fsvp_pkg::QIDX_W-1:0]     r_wr_ptr;
    logic [fsvp_pkg::QIDX_W-1:0]     r_rd_ptr;
    logic [fsvp_pkg::QCNT_W-1:0]     r_count;

    logic                            do_wr;
    logic                            do_rd;

    assign o_full  = (r_count == fsvp_pkg::QCNT_W'(fsvp_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/fsvp_back.sv
module fsvp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  fsvp_pkg::t_desc i_q_desc,
    output logic            o_q_rd,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte,
    output logic [31:0]     o_offset,
    output logic            o_last
);

    logic [2:0]  r_step;
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_data_byte;
    logic [31:0] r_offset;
    logic        r_last;

    logic        advance;
    logic [2:0]  count;
    logic [2:0]  d;
    logic        step_last;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] offset;

    assign advance = i_q_valid && (!r_out_valid || i_pop);

    always_comb begin
        count = 3'(i_q_desc.start) + i_q_desc.ndata + 3'(i_q_desc.err)
              + 3'(i_q_desc.slot_end);
        step_last = (r_step + 3'd1 == count);
        d = r_step - 3'(i_q_desc.start);
        data_byte = '0;
        offset = '0;
        if (i_q_desc.start && r_step == '0) begin
            kind = fsvp_pkg::KIND_OFFSET;
        end else if (d < i_q_desc.ndata) begin
            kind = fsvp_pkg::KIND_DATA;
            data_byte = i_q_desc.bytes[d[1:0]];
        end else if (i_q_desc.err) begin
            kind = fsvp_pkg::KIND_ERROR;
        end else begin
            kind = fsvp_pkg::KIND_OFFSET;
            offset = i_q_desc.offset;
        end
    end

    assign o_q_rd = advance && step_last;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind      <= kind;
            r_data_byte <= data_byte;
            r_offset    <= offset;
            r_last      <= step_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_step <= step_last ? 3'd0 : r_step + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data_byte;
    assign o_offset    = r_offset;
    assign o_last      = r_last;

endmodule

>>> rtl/core/fixed_slot_to_varlen_packer_unit.sv
// Channel   Direction  Handshake                 Payload
// units     in         push / full               i_unit[31:0], i_block_start
// results   out        empty / pop               o_kind[1:0], o_data_byte[7:0],
//                                                o_offset[31:0], o_last
// config    in         i_cfg_we                  i_cfg_idx[1:0], i_cfg_data[31:0]
//
// The front end takes one unit per cycle while the four-entry descriptor queue has room.
// The result side delivers one request per cycle while results are popped; a unit that
// causes k results (up to six) holds the queue head until the last is issued; a unit
// that causes none takes no queue entry; each result is registered before the ports.
// Reset is synchronous and needs no clearing pass; either side may stall independently.
module fixed_slot_to_varlen_packer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fsvp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fsvp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [31:0]                        i_unit,
    input  logic                               i_block_start,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_kind,
    output logic [7:0]                         o_data_byte,
    output logic [31:0]                        o_offset,
    output logic                               o_last
);

    logic            q_wr;
    logic            q_rd;
    logic            q_full;
    logic            q_valid;
    fsvp_pkg::t_desc wr_desc;
    fsvp_pkg::t_desc rd_desc;

    fsvp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_unit        (i_unit),
        .i_block_start (i_block_start),
        .i_q_full      (q_full),
        .o_full        (full),
        .o_q_wr        (q_wr),
        .o_q_desc      (wr_desc)
    );

    fsvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_desc  (wr_desc),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (rd_desc)
    );

    fsvp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_desc    (rd_desc),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_offset    (o_offset),
        .o_last      (o_last)
    );

endmodule
